FILE: hw/rtl/thrs_pkg.sv
// ----------------------------------------------------------------------------
// thrs_pkg: shared types and constants of the tracklet hit run selector
// Buffer depth, register codes, input word, and the command/status structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package thrs_pkg;

	// hit buffer depth and derived widths
	localparam int MAX_TRACK_HITS = 64;
	localparam int IDX_W          = $clog2(MAX_TRACK_HITS);
	localparam int CNT_W          = $clog2(MAX_TRACK_HITS + 1);

	// configuration register codes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_HITS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROW_GAP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRACKS  = 2'd2;

	// register reset values
	localparam logic [7:0]  MIN_HITS_RST    = 8'd10;
	localparam logic [3:0]  MAX_ROW_GAP_RST = 4'd4;
	localparam logic [15:0] MAX_TRACKS_RST  = 16'd4096;

	// saturation limits of the run counters
	localparam logic [7:0] COUNT_SAT = 8'd255;
	localparam logic [4:0] GAP_SAT   = 5'd31;

	typedef struct packed {
		logic [7:0]  row_index;
		logic        first_row_flag;
		logic [7:0]  last_row_number;
		logic        hit_present;
		logic [15:0] hit_id;
		logic [31:0] hit_weight;
		logic [31:0] tracklet_weight;
	} in_word_t;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch the accepted input word
		logic eval;      // apply the row to the run state
		logic rd_en;     // read the next buffered hit
		logic load;      // load the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic emit;      // row closed a run that becomes a track
		logic ovf;       // row closed a run past the track limit
		logic last;      // the word being loaded ends the track
	} stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/thrs_ifs.sv
// ----------------------------------------------------------------------------
// thrs_ifs: valid/ready channels of the tracklet hit run selector
// Row channel into the block and hit result channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface thrs_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  row_index;
	logic        first_row_flag;
	logic [7:0]  last_row_number;
	logic        hit_present;
	logic [15:0] hit_id;
	logic [31:0] hit_weight;
	logic [31:0] tracklet_weight;

	modport source (
		output valid, row_index, first_row_flag, last_row_number, hit_present,
		       hit_id, hit_weight, tracklet_weight,
		input  ready
	);
	modport sink (
		input  valid, row_index, first_row_flag, last_row_number, hit_present,
		       hit_id, hit_weight, tracklet_weight,
		output ready
	);
endinterface

interface thrs_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] track_number;
	logic [23:0] first_hit_index;
	logic [7:0]  hit_count;
	logic [7:0]  out_row;
	logic [15:0] out_hit_id;
	logic        last_of_track;
	logic        truncated;
	logic        overflow_error;

	modport source (
		output valid, track_number, first_hit_index, hit_count, out_row,
		       out_hit_id, last_of_track, truncated, overflow_error,
		input  ready
	);
	modport sink (
		input  valid, track_number, first_hit_index, hit_count, out_row,
		       out_hit_id, last_of_track, truncated, overflow_error,
		output ready
	);
endinterface

`default_nettype wire

FILE: hw/rtl/thrs_datapath.sv
// ----------------------------------------------------------------------------
// thrs_datapath: run state, hit buffer and output register
// Applies one row to the run counters, stores kept hits, and walks the
// buffer into the output register on command of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module thrs_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire thrs_pkg::in_word_t                  in_word,
	input  wire logic                                cfg_we,
	input  wire logic [thrs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [thrs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire thrs_pkg::cmd_t                      cmd,
	output thrs_pkg::stat_t                          stat,
	output logic [15:0]                              track_number,
	output logic [23:0]                              first_hit_index,
	output logic [7:0]                               hit_count,
	output logic [7:0]                               out_row,
	output logic [15:0]                              out_hit_id,
	output logic                                     last_of_track,
	output logic                                     truncated,
	output logic                                     overflow_error
);

	// configuration
	logic [7:0]  min_hits_q;
	logic [3:0]  max_row_gap_q;
	logic [15:0] max_tracks_q;

	// run state
	logic [7:0]  kept_q;
	logic [7:0]  shared_q;
	logic [4:0]  gap_q;
	logic        aband_q;
	logic        over_q;
	logic [15:0] tracks_q;
	logic [23:0] hits_wr_q;

	// captured row and latched track description
	thrs_pkg::in_word_t              row_q;
	logic [15:0]                     num_q;
	logic [23:0]                     base_q;
	logic [thrs_pkg::CNT_W-1:0]      cnt_q;
	logic                            trunc_q;
	logic                            ovf_q;
	logic [thrs_pkg::IDX_W-1:0]      k_q;

	// hit buffer and its read register
	logic [7:0]  mem_row [thrs_pkg::MAX_TRACK_HITS];
	logic [15:0] mem_id  [thrs_pkg::MAX_TRACK_HITS];
	logic [7:0]  rd_row_q;
	logic [15:0] rd_id_q;

	// row evaluation
	logic [7:0]  kept_eff, shared_eff, kept_new, shared_new, row_diff;
	logic [4:0]  gap_eff, gap_inc, gap_new;
	logic        over_eff, over_new, skip, early, own, share_ok, keep, wr_en;
	logic        close, qualify, ovf;
	logic [9:0]  reach;
	logic [11:0] shared_x10;
	logic [thrs_pkg::CNT_W-1:0] cnt;

	always_comb begin
		// a first row restarts the run before it is handled
		kept_eff   = row_q.first_row_flag ? '0 : kept_q;
		shared_eff = row_q.first_row_flag ? '0 : shared_q;
		gap_eff    = row_q.first_row_flag ? '0 : gap_q;
		over_eff   = row_q.first_row_flag ? 1'b0 : over_q;
		skip       = !row_q.first_row_flag && aband_q;

		// early stop: the row lies past the last row, or the run can no longer reach min_hits
		row_diff = row_q.last_row_number - row_q.row_index;
		reach    = 10'(row_diff) + 10'(kept_eff);
		early    = (row_q.row_index > row_q.last_row_number) ||
		           (reach < 10'(min_hits_q));

		gap_inc    = (gap_eff < thrs_pkg::GAP_SAT) ? gap_eff + 5'd1 : gap_eff;
		own        = row_q.hit_weight <= row_q.tracklet_weight;
		shared_x10 = ({4'b0, shared_eff} << 3) + ({4'b0, shared_eff} << 1);
		share_ok   = shared_x10 < 12'(kept_eff);
		keep       = row_q.hit_present && (own || share_ok);
		gap_new    = keep ? '0 : gap_inc;
		wr_en      = keep && (kept_eff < 8'(thrs_pkg::MAX_TRACK_HITS));
		over_new   = over_eff || (keep && !wr_en);
		kept_new   = (keep && kept_eff < thrs_pkg::COUNT_SAT) ? kept_eff + 8'd1 : kept_eff;
		shared_new = (keep && !own && shared_eff < thrs_pkg::COUNT_SAT) ?
		             shared_eff + 8'd1 : shared_eff;

		// run close and track qualification
		close   = (gap_new > {1'b0, max_row_gap_q}) ||
		          (row_q.row_index == row_q.last_row_number);
		qualify = !skip && !early && close && (kept_new >= min_hits_q);
		ovf     = qualify && (tracks_q >= max_tracks_q);
		cnt     = (kept_new < 8'(thrs_pkg::MAX_TRACK_HITS)) ?
		          thrs_pkg::CNT_W'(kept_new) : thrs_pkg::CNT_W'(thrs_pkg::MAX_TRACK_HITS);
	end

	assign stat.emit = qualify && !ovf && (cnt != '0);
	assign stat.ovf  = ovf;
	assign stat.last = ovf_q || (thrs_pkg::CNT_W'(k_q) == cnt_q - thrs_pkg::CNT_W'(1));

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_hits_q    <= thrs_pkg::MIN_HITS_RST;
			max_row_gap_q <= thrs_pkg::MAX_ROW_GAP_RST;
			max_tracks_q  <= thrs_pkg::MAX_TRACKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				thrs_pkg::CFG_MIN_HITS:    min_hits_q    <= cfg_data[7:0];
				thrs_pkg::CFG_MAX_ROW_GAP: max_row_gap_q <= cfg_data[3:0];
				thrs_pkg::CFG_MAX_TRACKS:  max_tracks_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// run state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q    <= '0;
			shared_q  <= '0;
			gap_q     <= '0;
			aband_q   <= 1'b0;
			over_q    <= 1'b0;
			tracks_q  <= '0;
			hits_wr_q <= '0;
		end else if (cmd.eval && !skip) begin
			if (early) begin
				kept_q   <= kept_eff;
				shared_q <= shared_eff;
				gap_q    <= gap_eff;
				over_q   <= over_eff;
				aband_q  <= 1'b1;
			end else if (close) begin
				kept_q   <= '0;
				shared_q <= '0;
				gap_q    <= '0;
				over_q   <= 1'b0;
				aband_q  <= ovf;
				if (qualify) begin
					tracks_q <= ovf ? '0 : tracks_q + 16'd1;
				end
				if (stat.emit) begin
					hits_wr_q <= hits_wr_q + 24'(cnt);
				end
			end else begin
				kept_q   <= kept_new;
				shared_q <= shared_new;
				gap_q    <= gap_new;
				over_q   <= over_new;
				aband_q  <= 1'b0;
			end
		end
	end

	// capture the row and latch the track description
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_q <= in_word;
		end
		if (cmd.eval) begin
			num_q   <= tracks_q;
			base_q  <= hits_wr_q;
			cnt_q   <= cnt;
			trunc_q <= over_new;
			ovf_q   <= ovf;
			k_q     <= '0;
		end else if (cmd.load) begin
			k_q <= k_q + thrs_pkg::IDX_W'(1);
		end
	end

	// hit buffer: write kept hits, read one entry per emitted word
	always_ff @(posedge clk) begin
		if (cmd.eval && !skip && !early && wr_en) begin
			mem_row[kept_eff[thrs_pkg::IDX_W-1:0]] <= row_q.row_index;
			mem_id[kept_eff[thrs_pkg::IDX_W-1:0]]  <= row_q.hit_id;
		end
		if (cmd.rd_en) begin
			rd_row_q <= mem_row[k_q];
			rd_id_q  <= mem_id[k_q];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (ovf_q) begin
				track_number    <= '0;
				first_hit_index <= '0;
				hit_count       <= '0;
				out_row         <= '0;
				out_hit_id      <= '0;
				last_of_track   <= 1'b0;
				truncated       <= 1'b0;
				overflow_error  <= 1'b1;
			end else begin
				track_number    <= num_q;
				first_hit_index <= base_q;
				hit_count       <= 8'(cnt_q);
				out_row         <= rd_row_q;
				out_hit_id      <= rd_id_q;
				last_of_track   <= stat.last;
				truncated       <= trunc_q;
				overflow_error  <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/thrs_ctrl.sv
// ----------------------------------------------------------------------------
// thrs_ctrl: sequencer of the tracklet hit run selector
// Accepts a row, has it evaluated, then walks the buffered hits of a
// finished track into the output register while holding off new rows.
// ----------------------------------------------------------------------------
`default_nettype none

module thrs_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            out_ready,
	output logic                 out_valid,
	output thrs_pkg::cmd_t       cmd,
	input  wire thrs_pkg::stat_t stat
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_RD,
		S_LOAD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   load;

	// load when the output register is empty or drains this cycle
	assign load = (state_q == S_LOAD) && (!out_valid_q || out_ready);

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign cmd.capture = in_valid && (state_q == S_IDLE);
	assign cmd.eval    = (state_q == S_EVAL);
	assign cmd.rd_en   = (state_q == S_RD);
	assign cmd.load    = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// hold the result word until taken
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (stat.ovf) state_q <= S_LOAD;
					else if (stat.emit) state_q <= S_RD;
					else state_q <= S_IDLE;
				end
				S_RD: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (load) state_q <= stat.last ? S_IDLE : S_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/tracklet_hit_run_selector_top.sv
// ----------------------------------------------------------------------------
// tracklet_hit_run_selector_top: hit selection and track cutting
// Rows of a tracklet come in on in_ch, one word per row, first to last.
// Kept hits gather in a 64-entry buffer; a closed run that qualifies is sent
// on out_ch as one word per buffered hit, or one overflow word at the limit.
//
// Channels: in_ch and out_ch are valid/ready; a word moves when both are
// high at a rising edge. Registers are written on cfg_we with cfg_index and
// cfg_data (min_hits, max_row_gap, max_tracks). The user must write them
// only while the block is idle; the block itself does not enforce this.
// Rows: a row is taken only while the sequencer is idle, then evaluated in
// its single evaluate step. A row that closes a track of n hits holds in_ch
// for one buffer read and one output load per hit on the single read port
// of the hit buffer; the first word is valid after the read and load steps.
// Stall: the output register holds a word until taken; while out_ch stalls
// the walk waits and no new row is accepted. Between tracks rows are taken
// even while the last word still waits.
// Reset: arst_n clears the run, the track and hit counters and the
// registers to 10, 4 and 4096. The buffer needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tracklet_hit_run_selector_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	thrs_in_if.sink                                in_ch,
	thrs_out_if.source                             out_ch,
	input  wire logic                              cfg_we,
	input  wire logic [thrs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [thrs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	thrs_pkg::in_word_t in_word;
	thrs_pkg::cmd_t     cmd;
	thrs_pkg::stat_t    stat;

	// gather the row word
	assign in_word.row_index       = in_ch.row_index;
	assign in_word.first_row_flag  = in_ch.first_row_flag;
	assign in_word.last_row_number = in_ch.last_row_number;
	assign in_word.hit_present     = in_ch.hit_present;
	assign in_word.hit_id          = in_ch.hit_id;
	assign in_word.hit_weight      = in_ch.hit_weight;
	assign in_word.tracklet_weight = in_ch.tracklet_weight;

	thrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.cmd       (cmd),
		.stat      (stat)
	);

	thrs_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_word         (in_word),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd             (cmd),
		.stat            (stat),
		.track_number    (out_ch.track_number),
		.first_hit_index (out_ch.first_hit_index),
		.hit_count       (out_ch.hit_count),
		.out_row         (out_ch.out_row),
		.out_hit_id      (out_ch.out_hit_id),
		.last_of_track   (out_ch.last_of_track),
		.truncated       (out_ch.truncated),
		.overflow_error  (out_ch.overflow_error)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/thrs_checker.sv
// ----------------------------------------------------------------------------
// thrs_checker: port-level checks of the tracklet hit run selector
// Watches the channels of the top level over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module thrs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] track_number,
	input wire logic [23:0] first_hit_index,
	input wire logic [7:0]  hit_count,
	input wire logic [7:0]  out_row,
	input wire logic [15:0] out_hit_id,
	input wire logic        last_of_track,
	input wire logic        truncated,
	input wire logic        overflow_error
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(track_number) &&
		$stable(first_hit_index) && $stable(hit_count) && $stable(out_row) &&
		$stable(out_hit_id) && $stable(last_of_track) && $stable(truncated) &&
		$stable(overflow_error))
		else $error("result word changed while stalled");

	// an accepted row is evaluated before the next one is taken
	a_one_row: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("row accepted during evaluation");

	// an overflow word carries nothing else
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow_error |-> track_number == 16'd0 &&
		first_hit_index == 24'd0 && hit_count == 8'd0 && out_row == 8'd0 &&
		out_hit_id == 16'd0 && !last_of_track && !truncated)
		else $error("overflow word with nonzero fields");

	// a track word counts at least one and at most a buffer of hits
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !overflow_error |-> hit_count != 8'd0 &&
		hit_count <= 8'(thrs_pkg::MAX_TRACK_HITS))
		else $error("track word hit count out of range");

endmodule

bind tracklet_hit_run_selector_top thrs_checker u_thrs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_ch.valid),
	.in_ready        (in_ch.ready),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.track_number    (out_ch.track_number),
	.first_hit_index (out_ch.first_hit_index),
	.hit_count       (out_ch.hit_count),
	.out_row         (out_ch.out_row),
	.out_hit_id      (out_ch.out_hit_id),
	.last_of_track   (out_ch.last_of_track),
	.truncated       (out_ch.truncated),
	.overflow_error  (out_ch.overflow_error)
);

`default_nettype wire

FILE: bench/thrs_hit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// thrs_hit_checker: hit word predictor and checker of the run selector
// Watches the row channel, the hit channel and the register port. Every
// accepted row word updates a private copy of the run state. Every hit word
// it causes goes on a queue, and each accepted hit word is compared against
// the oldest queued word. The count of failures is handed to the top level.
// ----------------------------------------------------------------------------

module thrs_hit_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	thrs_in_if                                rows,
	thrs_out_if                               hits,
	input  logic                              cfg_we,
	input  logic [thrs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [thrs_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                fails,
	output int                                words_due,
	output int                                words_seen,
	output int                                tracks_seen,
	output int                                overflows_seen,
	output int                                truncated_seen
);
	import thrs_pkg::*;

	typedef struct packed {
		logic [15:0] track_number;
		logic [23:0] first_hit_index;
		logic [7:0]  hit_count;
		logic [7:0]  out_row;
		logic [15:0] out_hit_id;
		logic        last_of_track;
		logic        truncated;
		logic        overflow_error;
	} hit_word_t;

	// register copies
	logic [7:0]  min_hits;
	logic [3:0]  max_row_gap;
	logic [15:0] max_tracks;

	// run state copy
	logic [7:0]  buf_row [MAX_TRACK_HITS];
	logic [15:0] buf_id  [MAX_TRACK_HITS];
	logic [7:0]  kept;
	logic [7:0]  shared;
	logic [4:0]  gap;
	logic        abandoned;
	logic        overfull;
	logic [15:0] tracks_made;
	logic [23:0] hits_written;

	hit_word_t track_words_due[$];

	in_word_t  row_word;
	hit_word_t got;

	assign row_word = {rows.row_index, rows.first_row_flag, rows.last_row_number,
	                   rows.hit_present, rows.hit_id, rows.hit_weight,
	                   rows.tracklet_weight};
	assign got = {hits.track_number, hits.first_hit_index, hits.hit_count, hits.out_row,
	              hits.out_hit_id, hits.last_of_track, hits.truncated,
	              hits.overflow_error};

	task automatic clear_run();
		kept = '0;
		shared = '0;
		gap = '0;
		overfull = 1'b0;
	endtask

	// apply one row to the run and queue the hit words it releases
	task automatic select_row_hits(input in_word_t w);
		logic        own;
		int          cnt;
		logic [15:0] num;
		hit_word_t   word;
		if (w.first_row_flag) begin
			clear_run();
			abandoned = 1'b0;
		end
		if (abandoned)
			return;
		// drop the tracklet past the last row or once min_hits is out of reach
		if (w.row_index > w.last_row_number ||
		    int'(w.last_row_number) - int'(w.row_index) + int'(kept) < int'(min_hits)) begin
			abandoned = 1'b1;
			return;
		end

		if (gap < GAP_SAT)
			gap = gap + 5'd1;
		if (w.hit_present) begin
			own = (w.hit_weight <= w.tracklet_weight);
			if (own || 10 * int'(shared) < int'(kept)) begin
				gap = '0;
				if (int'(kept) < MAX_TRACK_HITS) begin
					buf_row[kept] = w.row_index;
					buf_id[kept]  = w.hit_id;
				end else begin
					overfull = 1'b1;
				end
				if (kept < COUNT_SAT)
					kept = kept + 8'd1;
				if (!own && shared < COUNT_SAT)
					shared = shared + 8'd1;
			end
		end

		// close the run on a long gap or on the last row
		if (gap > {1'b0, max_row_gap} || w.row_index == w.last_row_number) begin
			if (kept >= min_hits) begin
				num = tracks_made;
				tracks_made = tracks_made + 16'd1;
				if (num >= max_tracks) begin
					word = '0;
					word.overflow_error = 1'b1;
					track_words_due.push_back(word);
					tracks_made = '0;
					abandoned = 1'b1;
				end else begin
					cnt = (int'(kept) < MAX_TRACK_HITS) ? int'(kept) : MAX_TRACK_HITS;
					for (int k = 0; k < cnt; k++) begin
						word.track_number    = num;
						word.first_hit_index = hits_written;
						word.hit_count       = 8'(cnt);
						word.out_row         = buf_row[k];
						word.out_hit_id      = buf_id[k];
						word.last_of_track   = (k == cnt - 1);
						word.truncated       = overfull;
						word.overflow_error  = 1'b0;
						track_words_due.push_back(word);
					end
					hits_written = hits_written + 24'(cnt);
				end
			end
			clear_run();
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
	                           input int unsigned seen);
		if (want != seen) begin
			fails++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
		end
	endtask

	// compare the accepted hit word against the oldest prediction
	task automatic check_hit_word();
		hit_word_t want;
		if (track_words_due.size() == 0) begin
			fails++;
			$display("%0t: expected no hit word, got track %0d row %0d id %0d ovf %0d",
			         $time, got.track_number, got.out_row, got.out_hit_id,
			         got.overflow_error);
			return;
		end
		want = track_words_due.pop_front();
		check_field("track_number", want.track_number, got.track_number);
		check_field("first_hit_index", want.first_hit_index, got.first_hit_index);
		check_field("hit_count", want.hit_count, got.hit_count);
		check_field("out_row", want.out_row, got.out_row);
		check_field("out_hit_id", want.out_hit_id, got.out_hit_id);
		check_field("last_of_track", want.last_of_track, got.last_of_track);
		check_field("truncated", want.truncated, got.truncated);
		check_field("overflow_error", want.overflow_error, got.overflow_error);
		words_seen++;
		if (want.overflow_error)
			overflows_seen++;
		if (want.last_of_track) begin
			tracks_seen++;
			if (want.truncated)
				truncated_seen++;
		end
	endtask

	// track registers, rows and hit words at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_hits       = MIN_HITS_RST;
			max_row_gap    = MAX_ROW_GAP_RST;
			max_tracks     = MAX_TRACKS_RST;
			clear_run();
			abandoned      = 1'b0;
			tracks_made    = '0;
			hits_written   = '0;
			track_words_due.delete();
			fails          = 0;
			words_seen     = 0;
			tracks_seen    = 0;
			overflows_seen = 0;
			truncated_seen = 0;
			words_due     <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_HITS:    min_hits    = cfg_data[7:0];
					CFG_MAX_ROW_GAP: max_row_gap = cfg_data[3:0];
					CFG_MAX_TRACKS:  max_tracks  = cfg_data;
					default: ;
				endcase
			end
			if (hits.valid && hits.ready)
				check_hit_word();
			if (rows.valid && rows.ready)
				select_row_hits(row_word);
			words_due <= track_words_due.size();
		end
	end

endmodule

FILE: bench/tracklet_hit_run_selector_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tracklet_hit_run_selector_top_tb: testbench of the tracklet hit run selector
// Resets the block, sends random tracklets, a short directed set of rows, then
// more under several register settings, with random gaps on the row channel
// and random stalls on the hit channel. The checker beside the block predicts
// and compares every hit word; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------

module tracklet_hit_run_selector_top_tb;
	import thrs_pkg::*;

	localparam int CLK_PERIOD   = 8;
	localparam int DRAIN_CYCLES = 10;
	localparam int MAX_IDLE     = 12;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int   fails;
	int   words_due;
	int   words_seen;
	int   tracks_seen;
	int   overflows_seen;
	int   truncated_seen;
	int   rows_sent;
	logic tx_calm;
	logic rx_calm;

	thrs_in_if  row_ch ();
	thrs_out_if hit_ch ();

	tracklet_hit_run_selector_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (row_ch),
		.out_ch    (hit_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	thrs_hit_checker hit_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.rows           (row_ch),
		.hits           (hit_ch),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fails          (fails),
		.words_due      (words_due),
		.words_seen     (words_seen),
		.tracks_seen    (tracks_seen),
		.overflows_seen (overflows_seen),
		.truncated_seen (truncated_seen)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// end the run if the block hangs
	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

	// take hit words with random stalls, calm stretches in between
	initial begin : hit_sink
		int stall;
		int left;
		hit_ch.ready <= 1'b0;
		left = 0;
		rx_calm = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (left == 0) begin
				rx_calm = ($urandom_range(2, 0) == 0);
				left = $urandom_range(40, 8);
			end
			left--;
			stall = rx_calm ? 0 : $urandom_range(MAX_IDLE, 0);
			if (stall > 0) begin
				hit_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			hit_ch.ready <= 1'b1;
			do @(posedge clk); while (!(hit_ch.valid && hit_ch.ready));
		end
	end

	function automatic in_word_t hit_row(input int row, input bit first, input int last,
	                                     input bit present, input logic [15:0] id,
	                                     input logic [31:0] hw, input logic [31:0] tw);
		in_word_t w;
		w.row_index       = 8'(row);
		w.first_row_flag  = first;
		w.last_row_number = 8'(last);
		w.hit_present     = present;
		w.hit_id          = id;
		w.hit_weight      = hw;
		w.tracklet_weight = tw;
		return w;
	endfunction

	// send one row word after a random gap, hold it until taken
	task automatic send_row(input in_word_t w);
		int idle;
		idle = tx_calm ? 0 : $urandom_range(MAX_IDLE, 0);
		if (idle > 0) begin
			row_ch.valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		row_ch.row_index       <= w.row_index;
		row_ch.first_row_flag  <= w.first_row_flag;
		row_ch.last_row_number <= w.last_row_number;
		row_ch.hit_present     <= w.hit_present;
		row_ch.hit_id          <= w.hit_id;
		row_ch.hit_weight      <= w.hit_weight;
		row_ch.tracklet_weight <= w.tracklet_weight;
		row_ch.valid           <= 1'b1;
		do @(posedge clk); while (!row_ch.ready);
		rows_sent++;
	endtask

	// drop valid and wait until every predicted word has arrived
	task automatic settle();
		row_ch.valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] mh, input logic [3:0] gap_max,
	                          input logic [15:0] mt);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MIN_HITS;
		cfg_data  <= {8'd0, mh};
		@(posedge clk);
		cfg_index <= CFG_MAX_ROW_GAP;
		cfg_data  <= {12'd0, gap_max};
		@(posedge clk);
		cfg_index <= CFG_MAX_TRACKS;
		cfg_data  <= mt;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// one tracklet of consecutive rows with random content, some noise words
	task automatic send_tracklet(input int long_pct);
		int       len;
		int       start;
		int       last;
		int       density;
		int       own_pct;
		in_word_t w;
		tx_calm = ($urandom_range(3, 0) == 0);
		len = ($urandom_range(99, 0) < long_pct) ? $urandom_range(110, 66)
		                                         : $urandom_range(30, 1);
		start = $urandom_range(256 - len, 0);
		last = start + len - 1;
		if ($urandom_range(9, 0) == 0)
			last = $urandom_range(255, 0);
		case ($urandom_range(2, 0))
			0:       density = 50;
			1:       density = 80;
			default: density = 97;
		endcase
		case ($urandom_range(2, 0))
			0:       own_pct = 55;
			1:       own_pct = 85;
			default: own_pct = 100;
		endcase
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(11, 0) == 0) begin
				w.row_index       = 8'($urandom);
				w.first_row_flag  = 1'($urandom);
				w.last_row_number = 8'($urandom);
				w.hit_present     = 1'($urandom);
				w.hit_id          = 16'($urandom);
				w.hit_weight      = $urandom;
				w.tracklet_weight = $urandom;
			end else begin
				w.row_index       = 8'(start + k);
				w.first_row_flag  = (k == 0);
				w.last_row_number = 8'(last);
				w.hit_present     = ($urandom_range(99, 0) < density);
				w.hit_id          = 16'($urandom);
				if ($urandom_range(99, 0) < own_pct) begin
					w.tracklet_weight = $urandom;
					w.hit_weight = ($urandom_range(9, 0) == 0) ? w.tracklet_weight
					             : $urandom_range(w.tracklet_weight, 0);
				end else begin
					w.tracklet_weight = $urandom_range(32'hFFFF_FFFE, 0);
					w.hit_weight = $urandom_range(32'hFFFF_FFFF, w.tracklet_weight + 1);
				end
			end
			send_row(w);
		end
	endtask

	task automatic run_phase(input logic [7:0] mh, input logic [3:0] gap_max,
	                         input logic [15:0] mt, input int budget, input int long_pct);
		int stop;
		settle();
		set_config(mh, gap_max, mt);
		stop = rows_sent + budget;
		while (rows_sent < stop)
			send_tracklet(long_pct);
	endtask

	initial begin : stimulus
		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_index              <= CFG_MIN_HITS;
		cfg_data               <= '0;
		row_ch.valid           <= 1'b0;
		row_ch.row_index       <= '0;
		row_ch.first_row_flag  <= 1'b0;
		row_ch.last_row_number <= '0;
		row_ch.hit_present     <= 1'b0;
		row_ch.hit_id          <= '0;
		row_ch.hit_weight      <= '0;
		row_ch.tracklet_weight <= '0;
		tx_calm = 1'b0;
		rows_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// random tracklets under the reset settings
		while (rows_sent < 45)
			send_tracklet(5);

		// directed rows: two hits per track, no gap tolerated
		settle();
		set_config(8'd2, 4'd0, 16'hFFFF);
		tx_calm = 1'b0;
		// row past the last row, then a row of the abandoned tracklet
		send_row(hit_row(200, 1, 100, 1, 16'h0001, 32'd0, 32'd0));
		send_row(hit_row(0, 0, 255, 1, 16'h0002, 32'd0, 32'd0));
		// owned hit at equal weights, shared hit, refused shared hit closes
		send_row(hit_row(0, 1, 255, 1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_row(hit_row(1, 0, 255, 1, 16'h0000, 32'd1, 32'd0));
		send_row(hit_row(2, 0, 255, 1, 16'h5A5A, 32'hFFFF_FFFF, 32'd0));
		// short run closed by a missing hit, too few hits
		send_row(hit_row(3, 0, 255, 1, 16'hA5A5, 32'd0, 32'd0));
		send_row(hit_row(4, 0, 255, 0, 16'h1234, 32'd7, 32'd9));
		// run closed by the last row
		send_row(hit_row(253, 1, 255, 1, 16'h0100, 32'd3, 32'd3));
		send_row(hit_row(254, 0, 255, 1, 16'h0200, 32'd0, 32'd5));
		send_row(hit_row(255, 0, 255, 1, 16'hFFFF, 32'd0, 32'hFFFF_FFFF));
		// min_hits out of reach on the first row, next row ignored
		send_row(hit_row(250, 1, 250, 1, 16'h0300, 32'd0, 32'd0));
		send_row(hit_row(251, 0, 250, 1, 16'h0301, 32'd0, 32'd0));
		// row numbers out of order are only recorded
		send_row(hit_row(10, 1, 200, 1, 16'h0400, 32'd1, 32'd2));
		send_row(hit_row(7, 0, 200, 1, 16'h0401, 32'd1, 32'd2));
		send_row(hit_row(200, 0, 200, 1, 16'h0402, 32'd1, 32'd2));

		// a single kept hit qualifies a run, widest gap
		run_phase(8'd1, 4'd15, 16'hFFFF, 50, 5);
		// long runs overrun the hit buffer
		run_phase(8'd20, 4'd15, 16'hFFFF, 70, 35);
		// tiny track limit, repeated overflow
		run_phase(8'd3, 4'd1, 16'd2, 45, 5);
		// min_hits of 160, no gap, a track limit of one
		run_phase(8'd160, 4'd0, 16'd1, 20, 0);
		run_phase(8'd6, 4'd2, 16'hFFFF, 55, 10);
		// back to the reset settings
		run_phase(MIN_HITS_RST, MAX_ROW_GAP_RST, MAX_TRACKS_RST, 25, 5);
		settle();

		$display("rows sent: %0d; hit words checked: %0d in %0d tracks",
		         rows_sent, words_seen, tracks_seen);
		$display("overflow words: %0d; truncated tracks: %0d",
		         overflows_seen, truncated_seen);
		if (fails == 0 && words_due == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/thrs_pkg.sv
hw/rtl/thrs_ifs.sv
hw/rtl/thrs_datapath.sv
hw/rtl/thrs_ctrl.sv
hw/rtl/tracklet_hit_run_selector_top.sv
hw/rtl/thrs_checker.sv
bench/thrs_hit_checker.sv
bench/tracklet_hit_run_selector_top_tb.sv
